### rtl/dac_pkg.sv
package dac_pkg;

   localparam int BLOCK = 64;
   localparam int ADDR_W = 6;
   localparam int CNT_W = 7;

   localparam logic [2:0] CSR_HOT_SCALE = 3'd0;
   localparam logic [2:0] CSR_SENS_SCALE = 3'd1;
   localparam logic [2:0] CSR_CLIP_LEVEL = 3'd2;
   localparam logic [2:0] CSR_TO_HOT = 3'd3;
   localparam logic [2:0] CSR_TO_SENS = 3'd4;
   localparam logic [2:0] CSR_RELEASE = 3'd5;

   localparam logic signed [24:0] OUT_MAX = 25'sd8388607;
   localparam logic signed [24:0] OUT_MIN = -25'sd8388608;

   typedef struct packed {
      logic       target;
      logic       prev;
      logic       switched;
      logic       fade;
      logic       hclip;
      logic       sclip;
      logic [15:0] hpeak;
      logic [15:0] speak;
      logic [CNT_W-1:0] count;
   } blk_type;

   function automatic logic [15:0] mag16(input logic signed [15:0] s);
      logic [16:0] e;
      begin
         e = s[15] ? (17'd0 - {{1{s[15]}}, s}) : {1'b0, s};
         mag16 = e[15:0];
      end
   endfunction

   function automatic logic [23:0] sat24(input logic signed [33:0] v);
      begin
         if (v > 34'(OUT_MAX)) sat24 = OUT_MAX[23:0];
         else if (v < 34'(OUT_MIN)) sat24 = OUT_MIN[23:0];
         else sat24 = v[23:0];
      end
   endfunction

endpackage

### rtl/dac_ram.sv
module dac_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/dac_div.sv
module dac_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  logic signed [33:0]         num,
   input  logic [dac_pkg::CNT_W-1:0]  den,
   output logic                       done,
   output logic signed [33:0]         quo
);
   logic [33:0] rem_ff, rem_in;
   logic [33:0] q_ff, q_in;
   logic [5:0]  n_ff, n_in;
   logic        run_ff, run_in;
   logic        neg_ff, neg_in;
   logic        done_ff, done_in;
   logic [34:0] trial;

   always_comb begin
      rem_in = rem_ff;
      q_in = q_ff;
      n_in = n_ff;
      run_in = run_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      trial = 35'd0;
      if (go) begin
         run_in = 1'b1;
         neg_in = num[33];
         q_in = num[33] ? 34'd0 - num : num;
         rem_in = 34'd0;
         n_in = 6'd34;
      end else if (run_ff) begin
         trial = {rem_ff, q_ff[33]} - {28'd0, den};
         if (!trial[34]) begin
            rem_in = trial[33:0];
            q_in = {q_ff[32:0], 1'b1};
         end else begin
            rem_in = {rem_ff[32:0], q_ff[33]};
            q_in = {q_ff[32:0], 1'b0};
         end
         n_in = n_ff - 6'd1;
         if (n_ff == 6'd1) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      q_ff <= q_in;
      n_ff <= n_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quo = neg_ff ? 34'sd0 - $signed(q_ff) : $signed(q_ff);
endmodule

### rtl/dual_adc_autorange_crossfade.sv
// channel   direction  handshake               payload
// req       in         start & !busy           hot_sample, sensitive_sample, block_end
// rsp       out        rsp_valid (one cycle)   out_sample and status
// csr       in         csr_valid & csr_ready   csr_index, csr_data
// a request is written into the buffers when accepted; the block ends on block_end or after 64 pairs
// then busy stays high while each result is read from the buffers, scaled and sent:
// plain results pass READ, MUL, MIX and SEND; a crossfade adds DIV (one serial divider)
// reset clears control state; buffer contents are not cleared
// the receiver cannot stall; no new request is taken until the whole block has been sent
module dual_adc_autorange_crossfade (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_hot_sample,
   input  logic signed [15:0] req_sensitive_sample,
   input  logic               req_block_end,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_data,
   output logic               rsp_valid,
   output logic signed [23:0] rsp_out_sample,
   output logic               rsp_out_last,
   output logic               rsp_active_range,
   output logic               rsp_range_switched,
   output logic               rsp_hot_clip,
   output logic               rsp_sensitive_clip,
   output logic               rsp_output_clip,
   output logic [15:0]        rsp_hot_peak,
   output logic [15:0]        rsp_sensitive_peak
);
   localparam logic [2:0] ST_FILL = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_MUL = 3'd3;
   localparam logic [2:0] ST_MIX = 3'd4;
   localparam logic [2:0] ST_DIV = 3'd5;
   localparam logic [2:0] ST_SEND = 3'd6;

   logic [2:0] st_ff, st_in;
   logic [15:0] hot_scale_ff, sens_scale_ff, clip_ff, to_hot_ff, to_sens_ff;
   logic [23:0] release_ff;
   logic [15:0] hpk_ff, hpk_in, spk_ff, spk_in;
   logic [dac_pkg::CNT_W-1:0] fill_ff, fill_in, idx_ff, idx_in;
   logic range_ff, range_in, started_ff, started_in;
   logic [31:0] quiet_ff, quiet_in;
   dac_pkg::blk_type blk_ff, blk_in;

   logic accept;
   logic [dac_pkg::ADDR_W-1:0] rd_addr;
   logic [15:0] hot_rd, sens_rd;
   logic signed [33:0] hprod_ff, hprod_in, sprod_ff, sprod_in;
   logic signed [33:0] val_ff, val_in, diff;
   logic signed [33:0] oldv, newv, num_ff, num_in;
   logic div_start_ff, div_done;
   logic signed [33:0] div_q;
   logic rsp_v_ff, rsp_v_in;
   logic [23:0] rsp_s_ff, rsp_s_in;
   logic rsp_l_ff, rsp_l_in;
   logic [dac_pkg::CNT_W-1:0] fill_next;
   logic [15:0] hm, sm;
   logic r0, tgt;
   logic [32:0] qsum;
   logic [31:0] qnew;

   assign accept = start && !busy;
   assign busy = st_ff != ST_FILL;
   assign csr_ready = 1'b1;
   assign rd_addr = idx_ff[dac_pkg::ADDR_W-1:0];

   dac_ram #(.WIDTH(16), .DEPTH(dac_pkg::BLOCK)) u_hot_ram (
      .clock(clock), .wr_en(accept), .wr_addr(fill_ff[dac_pkg::ADDR_W-1:0]),
      .wr_data(req_hot_sample), .rd_addr(rd_addr), .rd_data(hot_rd));
   dac_ram #(.WIDTH(16), .DEPTH(dac_pkg::BLOCK)) u_sens_ram (
      .clock(clock), .wr_en(accept), .wr_addr(fill_ff[dac_pkg::ADDR_W-1:0]),
      .wr_data(req_sensitive_sample), .rd_addr(rd_addr), .rd_data(sens_rd));

   // divider start is registered at the same edge as the numerator
   dac_div u_div (
      .clock(clock), .reset(reset), .go(div_start_ff), .num(num_ff),
      .den(blk_ff.count), .done(div_done), .quo(div_q));

   always_comb begin
      st_in = st_ff;
      hpk_in = hpk_ff;
      spk_in = spk_ff;
      fill_in = fill_ff;
      idx_in = idx_ff;
      range_in = range_ff;
      started_in = started_ff;
      quiet_in = quiet_ff;
      blk_in = blk_ff;
      hprod_in = hprod_ff;
      sprod_in = sprod_ff;
      val_in = val_ff;
      num_in = num_ff;
      rsp_v_in = 1'b0;
      rsp_s_in = rsp_s_ff;
      rsp_l_in = rsp_l_ff;
      hm = dac_pkg::mag16(req_hot_sample);
      sm = dac_pkg::mag16(req_sensitive_sample);
      fill_next = fill_ff + 7'd1;
      r0 = range_ff;
      tgt = 1'b0;
      qsum = 33'd0;
      qnew = 32'd0;
      newv = blk_ff.target ? hprod_ff : sprod_ff;
      oldv = blk_ff.prev ? hprod_ff : sprod_ff;
      diff = newv - oldv;
      unique case (st_ff)
         ST_FILL: begin
            if (accept) begin
               if (hm > hpk_ff) hpk_in = hm;
               if (sm > spk_ff) spk_in = sm;
               fill_in = fill_next;
               if (req_block_end || fill_next == 7'(dac_pkg::BLOCK)) st_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!started_ff) r0 = spk_ff >= to_hot_ff;
            started_in = 1'b1;
            tgt = r0;
            if (!r0) begin
               quiet_in = 32'd0;
               if (spk_ff >= to_hot_ff) tgt = 1'b1;
            end else if (spk_ff <= to_sens_ff) begin
               qsum = {1'b0, quiet_ff} + 33'(fill_ff);
               qnew = qsum[32] ? 32'hFFFF_FFFF : qsum[31:0];
               quiet_in = qnew;
               if (qnew >= 32'(release_ff)) begin
                  tgt = 1'b0;
                  quiet_in = 32'd0;
               end
            end else begin
               quiet_in = 32'd0;
            end
            blk_in.target = tgt;
            blk_in.prev = r0;
            blk_in.switched = tgt != r0;
            blk_in.hclip = hpk_ff >= clip_ff;
            blk_in.sclip = spk_ff >= clip_ff;
            blk_in.fade = (tgt != r0) && !(spk_ff >= clip_ff);
            blk_in.hpeak = hpk_ff;
            blk_in.speak = spk_ff;
            blk_in.count = fill_ff;
            range_in = tgt;
            idx_in = '0;
            st_in = ST_READ;
         end
         ST_READ: st_in = ST_MUL;
         ST_MUL: begin
            hprod_in = 34'($signed(hot_rd) * $signed({1'b0, hot_scale_ff})) >>> 12;
            sprod_in = 34'($signed(sens_rd) * $signed({1'b0, sens_scale_ff})) >>> 12;
            st_in = ST_MIX;
         end
         ST_MIX: begin
            if (blk_ff.fade) begin
               num_in = 34'(diff * $signed({1'b0, 7'(idx_ff + 7'd1)}));
               val_in = oldv;
               st_in = ST_DIV;
            end else begin
               val_in = newv;
               st_in = ST_SEND;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               val_in = val_ff + div_q;
               st_in = ST_SEND;
            end
         end
         ST_SEND: begin
            rsp_v_in = 1'b1;
            rsp_s_in = dac_pkg::sat24(val_ff);
            rsp_l_in = idx_ff + 7'd1 == blk_ff.count;
            idx_in = idx_ff + 7'd1;
            if (idx_ff + 7'd1 == blk_ff.count) begin
               st_in = ST_FILL;
               fill_in = '0;
               hpk_in = 16'd0;
               spk_in = 16'd0;
            end else begin
               st_in = ST_READ;
            end
         end
         default: st_in = ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_FILL;
         hot_scale_ff <= 16'd4096;
         sens_scale_ff <= 16'd4096;
         clip_ff <= 16'd32440;
         to_hot_ff <= 16'd29000;
         to_sens_ff <= 16'd8000;
         release_ff <= 24'd48000;
         hpk_ff <= '0;
         spk_ff <= '0;
         fill_ff <= '0;
         idx_ff <= '0;
         range_ff <= 1'b0;
         started_ff <= 1'b0;
         quiet_ff <= '0;
         rsp_v_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         hpk_ff <= hpk_in;
         spk_ff <= spk_in;
         fill_ff <= fill_in;
         idx_ff <= idx_in;
         range_ff <= range_in;
         started_ff <= started_in;
         quiet_ff <= quiet_in;
         rsp_v_ff <= rsp_v_in;
         div_start_ff <= (st_ff == ST_MIX) && blk_ff.fade;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               dac_pkg::CSR_HOT_SCALE: hot_scale_ff <= csr_data[15:0];
               dac_pkg::CSR_SENS_SCALE: sens_scale_ff <= csr_data[15:0];
               dac_pkg::CSR_CLIP_LEVEL: clip_ff <= csr_data[15:0];
               dac_pkg::CSR_TO_HOT: to_hot_ff <= csr_data[15:0];
               dac_pkg::CSR_TO_SENS: to_sens_ff <= csr_data[15:0];
               dac_pkg::CSR_RELEASE: release_ff <= csr_data;
               default: ;
            endcase
         end
      end
      blk_ff <= blk_in;
      hprod_ff <= hprod_in;
      sprod_ff <= sprod_in;
      val_ff <= val_in;
      num_ff <= num_in;
      rsp_s_ff <= rsp_s_in;
      rsp_l_ff <= rsp_l_in;
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_out_sample = rsp_s_ff;
   assign rsp_out_last = rsp_l_ff;
   assign rsp_active_range = blk_ff.target;
   assign rsp_range_switched = blk_ff.switched;
   assign rsp_hot_clip = blk_ff.hclip;
   assign rsp_sensitive_clip = blk_ff.sclip;
   assign rsp_output_clip = blk_ff.target ? blk_ff.hclip : blk_ff.sclip;
   assign rsp_hot_peak = blk_ff.hpeak;
   assign rsp_sensitive_peak = blk_ff.speak;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy || rsp_out_last) else $error("result outside emission");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_last |-> !busy) else $error("last result but still busy");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 7'(dac_pkg::BLOCK)) else $error("fill count overflow");
   a_started: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> started_ff) else $error("result before first decision");
`endif
endmodule
